@@ sv/stgen_pkg.sv @@
package stgen_pkg;

   localparam int CountWidth = 32;
   localparam int PhaseWidth = 16;
   localparam int OpWidth    = 2;

   localparam logic [OpWidth-1:0] OP_TICK  = 2'd0;
   localparam logic [OpWidth-1:0] OP_MOVE  = 2'd1;
   localparam logic [OpWidth-1:0] OP_CLEAR = 2'd2;

   localparam logic [PhaseWidth-1:0] PHASE_CARRY = 16'h8000;

   typedef struct packed {
      logic [OpWidth-1:0]           op;
      logic signed [CountWidth-1:0] steps;
   } req_type;

   typedef struct packed {
      logic                         step_pulse;
      logic                         direction;
      logic signed [CountWidth-1:0] remaining;
      logic signed [CountWidth-1:0] position;
   } rsp_type;

   typedef struct packed {
      logic [CountWidth-1:0] remaining;
      logic [CountWidth-1:0] position;
      logic [PhaseWidth-1:0] phase;
   } state_type;

endpackage

@@ sv/stgen_update.sv @@
module stgen_update
   import stgen_pkg::*;
(
   input  req_type               req,
   input  state_type             state,
   input  logic [PhaseWidth-1:0] increment,
   output state_type             state_next,
   output rsp_type               rsp
);

   logic [PhaseWidth-1:0] phase_sum;
   logic [CountWidth-1:0] remaining_step;
   logic [CountWidth-1:0] position_step;
   logic                  negative;
   logic                  pulse;

   assign phase_sum = state.phase + increment;
   assign negative  = state.remaining[CountWidth-1];
   assign remaining_step = negative ? state.remaining + CountWidth'(1)
                                    : state.remaining - CountWidth'(1);
   assign position_step  = negative ? state.position + CountWidth'(1)
                                    : state.position - CountWidth'(1);

   always_comb begin
      state_next = state;
      pulse      = 1'b0;
      unique case (req.op)
         OP_TICK: begin
            if (state.remaining != '0) begin
               state_next.phase = phase_sum;
               if ((phase_sum & PHASE_CARRY) != '0) begin
                  pulse                = 1'b1;
                  state_next.remaining = remaining_step;
                  state_next.position  = position_step;
                  state_next.phase     = phase_sum & ~PHASE_CARRY;
                  if (remaining_step == '0) begin
                     state_next.phase = '0;
                  end
               end
            end
         end
         OP_MOVE: begin
            state_next.remaining = state.remaining + req.steps;
         end
         OP_CLEAR: begin
            state_next = '0;
         end
         default: begin
            state_next = state;
         end
      endcase
   end

   always_comb begin
      rsp.step_pulse = pulse;
      rsp.direction  = pulse & ~negative;
      rsp.remaining  = state_next.remaining;
      rsp.position   = state_next.position;
   end

endmodule

@@ sv/stepper_phase_accumulator_stepgen.sv @@
// Step-pulse generator with a signed remaining-step count, a position counter
// and a 16-bit phase accumulator.
// Requests arrive on the req_ channel (req_valid, req_stall, req_data) and each
// one gives exactly one result on the rsp_ channel (rsp_valid, rsp_stall,
// rsp_data), in order. A request is a tick, a move by a signed step count or a
// clear of all counters.
// A request is held in the input register, the update is worked out from
// there in one pass and the result lands in the output register, from which
// it is presented on rsp_ until it is taken. One request is taken in every
// cycle while rsp_stall is low; the counters are updated at the same edge as
// the output register, so consecutive requests see each other's effects
// without a bubble. When the receiver stalls, the result holds and the input
// register fills; req_stall then rises until the result has been taken.
// The step increment is written through csr_write_enable and csr_write_data
// only while the block is idle; this is a rule for the user that the block
// itself does not enforce. Synchronous reset clears the counters, the
// accumulator, the increment and both valid flags.
module stepper_phase_accumulator_stepgen
   import stgen_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_write_enable,
   input  logic [PhaseWidth-1:0] csr_write_data
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   req_type               in_data_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   rsp_type               out_data_ff;
   state_type             state_ff;
   state_type             state_in;
   logic [PhaseWidth-1:0] increment_ff;
   rsp_type               rsp_next;
   logic                  out_free;
   logic                  advance;

   stgen_update u_update (
      .req        (in_data_ff),
      .state      (state_ff),
      .increment  (increment_ff),
      .state_next (state_in),
      .rsp        (rsp_next)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign in_valid_in  = req_valid || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         increment_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_write_enable) begin
            increment_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.remaining == state_ff.remaining
                     && rsp_data.position == state_ff.position))
      else $error("result counters differ from the held state");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase & PHASE_CARRY) == '0)
      else $error("phase accumulator kept its carry bit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.direction |-> rsp_data.step_pulse)
      else $error("direction set without a step pulse");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("input stalled with room downstream");

endmodule
